// ===== src/tga_pixel_stream_decoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// TGA pixel stream decoder assertion macros
// Shared property wrappers for the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef TGA_PIXEL_STREAM_DECODER_CORE_ASSERT_SVH
`define TGA_PIXEL_STREAM_DECODER_CORE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define TPSD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tga decoder check failed");

// A valid that is not taken must still be high on the next cycle.
`define TPSD_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (vld && !rdy) |=> vld) \
    else $error("tga decoder valid dropped while stalled");

`endif

// ===== src/tga_psd_pkg.sv =====
// ----------------------------------------------------------------------------
// TGA pixel stream decoder package
// Types, codes and colour unpacking shared by the decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tga_psd_pkg;

  localparam int MapDepthDflt = 256;
  localparam int QueueDepth   = 4;
  localparam int QueueAw      = 2;

  localparam logic [31:0] MAGENTA      = 32'hFF00FFFF;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

  typedef enum logic [1:0] {
    FMT_GREY8  = 2'd0,
    FMT_RGB15  = 2'd1,
    FMT_BGR24  = 2'd2,
    FMT_BGRA32 = 2'd3
  } pix_fmt_t;

  typedef enum logic [2:0] {
    REG_WIDTH     = 3'd0,
    REG_HEIGHT    = 3'd1,
    REG_PIX_FMT   = 3'd2,
    REG_MAP_PRES  = 3'd3,
    REG_MAP_ENT   = 3'd4,
    REG_MAP_FMT   = 3'd5,
    REG_RLE       = 3'd6,
    REG_ORIGIN    = 3'd7
  } cfg_reg_t;

  // Where the colour of a queued result comes from.
  typedef enum logic [1:0] {
    SRC_DIRECT  = 2'd0,
    SRC_INDEX   = 2'd1,
    SRC_MAGENTA = 2'd2,
    SRC_ERROR   = 2'd3
  } color_src_t;

  typedef struct packed {
    logic [15:0] image_width;
    logic [15:0] image_height;
    pix_fmt_t    pixel_format;
    logic        map_present;
    logic [15:0] map_entries;
    pix_fmt_t    map_entry_format;
    logic        rle_enabled;
    logic [1:0]  origin_flags;
  } cfg_t;

  typedef struct packed {
    color_src_t  src;
    pix_fmt_t    fmt;
    logic [31:0] raw;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        run_pending;
    logic        image_done;
  } job_t;

  typedef struct packed {
    logic        we;
    logic [7:0]  addr;
    logic [31:0] data;
  } pal_wr_t;

  // Colour packed as red, green, blue, alpha from the top byte down.
  function automatic logic [31:0] unpack_color(pix_fmt_t fmt, logic [31:0] v);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    a = ALPHA_OPAQUE;
    case (fmt)
      FMT_GREY8: begin
        r = v[7:0]; g = v[7:0]; b = v[7:0];
      end
      FMT_RGB15: begin
        r = {v[14:10], 3'b000};
        g = {v[9:5], 3'b000};
        b = {v[4:0], 3'b000};
      end
      FMT_BGR24: begin
        b = v[7:0]; g = v[15:8]; r = v[23:16];
      end
      default: begin
        b = v[7:0]; g = v[15:8]; r = v[23:16]; a = v[31:24];
      end
    endcase
    return {r, g, b, a};
  endfunction

endpackage

`default_nettype wire

// ===== src/tga_psd_if.sv =====
// ----------------------------------------------------------------------------
// TGA pixel stream decoder channels
// Valid/ready interfaces for the byte input and the pixel output.
// ----------------------------------------------------------------------------
`default_nettype none

interface tga_psd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;
  modport source (output valid, output op, output data_byte, input ready);
  modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface tga_psd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        run_pending;
  logic        image_done;
  logic        error;
  modport source (output valid, output pos_x, output pos_y, output red, output green,
                  output blue, output alpha, output run_pending, output image_done,
                  output error, input ready);
  modport sink (input valid, input pos_x, input pos_y, input red, input green,
                input blue, input alpha, input run_pending, input image_done,
                input error, output ready);
endinterface

`default_nettype wire

// ===== src/tga_pixel_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// TGA pixel stream decoder core
// Throughput is one item per cycle while the queue is not full; each item is
// parsed as it is accepted. Its result passes through the queue and a stage
// register to the output; a four-entry queue lets the two sides stall separately.
// Reset is synchronous and active low; all configuration returns to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_pixel_stream_decoder_core
  import tga_psd_pkg::*;
#(
  parameter int MAP_DEPTH = MapDepthDflt
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tga_psd_in_if.sink       in_ch,
  tga_psd_out_if.source    out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  // Configuration registers. Every write restarts the stream, but the
  // palette contents are kept so that a loaded map survives.
  cfg_t    cfg_r, cfg_nxt;
  logic    start_load;
  logic    q_full, push;
  job_t    job;
  pal_wr_t pal_wr;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH:    cfg_nxt.image_width      = cfg_wdata;
        REG_HEIGHT:   cfg_nxt.image_height     = cfg_wdata;
        REG_PIX_FMT:  cfg_nxt.pixel_format     = pix_fmt_t'(cfg_wdata[1:0]);
        REG_MAP_PRES: cfg_nxt.map_present      = cfg_wdata[0];
        REG_MAP_ENT:  cfg_nxt.map_entries      = cfg_wdata;
        REG_MAP_FMT:  cfg_nxt.map_entry_format = pix_fmt_t'(cfg_wdata[1:0]);
        REG_RLE:      cfg_nxt.rle_enabled      = cfg_wdata[0];
        REG_ORIGIN:   cfg_nxt.origin_flags     = cfg_wdata[1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width      <= 16'd1;
      cfg_r.image_height     <= 16'd1;
      cfg_r.pixel_format     <= FMT_BGR24;
      cfg_r.map_present      <= 1'b0;
      cfg_r.map_entries      <= 16'd0;
      cfg_r.map_entry_format <= FMT_BGR24;
      cfg_r.rle_enabled      <= 1'b0;
      cfg_r.origin_flags     <= 2'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front end restarts on the same edge as the write, so it takes its
  // starting phase from the value being written rather than the old one.
  assign start_load = rst_n && cfg_nxt.map_present && (cfg_nxt.map_entries != 16'd0);

  // Front end: takes each item, steps the parser state and queues any result.
  tga_psd_front #(
    .MAP_DEPTH (MAP_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .restart    (cfg_we),
    .start_load (start_load),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .job        (job),
    .pal_wr     (pal_wr)
  );

  // Back end: drains the queue, resolves the colour and drives the output.
  tga_psd_back #(
    .MAP_DEPTH (MAP_DEPTH)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .job    (job),
    .pal_wr (pal_wr),
    .q_full (q_full),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ===== src/tga_psd_front.sv =====
// ----------------------------------------------------------------------------
// TGA decoder front end
// Parses map, packet headers and pixel bytes, tracks position, queues results.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_psd_front
  import tga_psd_pkg::*;
#(
  parameter int MAP_DEPTH = MapDepthDflt
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      restart,
  input  wire logic      start_load,
  tga_psd_in_if.sink     in_ch,
  input  wire logic      q_full,
  output      logic      push,
  output      job_t      job,
  output      pal_wr_t   pal_wr
);

  typedef enum logic [2:0] {
    PH_LOAD = 3'b001,
    PH_PIX  = 3'b010,
    PH_DONE = 3'b100
  } phase_t;

  localparam logic [16:0] DEPTH17 = 17'(MAP_DEPTH);

  phase_t      phase_r, phase_nxt;
  logic [15:0] count_r, count_nxt;
  logic [23:0] gather_r, gather_nxt;
  logic [1:0]  bpos_r, bpos_nxt;
  logic [7:0]  pkt_left_r, pkt_left_nxt;
  logic        pkt_rep_r, pkt_rep_nxt;
  logic [31:0] rep_raw_r, rep_raw_nxt;
  color_src_t  rep_src_r, rep_src_nxt;
  pix_fmt_t    rep_fmt_r, rep_fmt_nxt;
  logic [6:0]  rep_left_r, rep_left_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;

  logic        acc;
  logic [31:0] gv;
  pix_fmt_t    gfmt;
  logic        g_done;
  logic [15:0] w16, h16;
  logic        col_last, row_last;
  logic        emit, err;
  logic [31:0] e_raw;
  color_src_t  e_src;
  pix_fmt_t    e_fmt;
  color_src_t  px_src;

  assign in_ch.ready = !q_full;
  assign acc = in_ch.valid && !q_full;

  assign w16 = (cfg.image_width == 16'd0) ? 16'd1 : cfg.image_width;
  assign h16 = (cfg.image_height == 16'd0) ? 16'd1 : cfg.image_height;
  assign col_last = ({1'b0, col_r} + 17'd1) >= {1'b0, w16};
  assign row_last = ({1'b0, row_r} + 17'd1) >= {1'b0, h16};

  assign gv = {8'h00, gather_r} | ({24'h0, in_ch.data_byte} << {bpos_r, 3'b000});
  assign gfmt = (phase_r == PH_LOAD) ? cfg.map_entry_format :
                (cfg.map_present ? FMT_GREY8 : cfg.pixel_format);
  assign g_done = bpos_r >= gfmt;

  always_comb begin
    if (!cfg.map_present) begin
      px_src = SRC_DIRECT;
    end else if (({8'h00, gv[7:0]} < count_r) && ({9'h000, gv[7:0]} < DEPTH17)) begin
      px_src = SRC_INDEX;
    end else begin
      px_src = SRC_MAGENTA;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    gather_nxt   = gather_r;
    bpos_nxt     = bpos_r;
    pkt_left_nxt = pkt_left_r;
    pkt_rep_nxt  = pkt_rep_r;
    rep_raw_nxt  = rep_raw_r;
    rep_src_nxt  = rep_src_r;
    rep_fmt_nxt  = rep_fmt_r;
    rep_left_nxt = rep_left_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    emit         = 1'b0;
    err          = 1'b0;
    e_raw        = gv;
    e_src        = px_src;
    e_fmt        = cfg.pixel_format;
    pal_wr       = '0;
    push         = 1'b0;
    job          = '0;

    if (acc) begin
      if (in_ch.op) begin
        if (phase_r != PH_PIX || rep_left_r == 7'd0) begin
          err = 1'b1;
        end else begin
          rep_left_nxt = rep_left_r - 7'd1;
          emit  = 1'b1;
          e_raw = rep_raw_r;
          e_src = rep_src_r;
          e_fmt = rep_fmt_r;
        end
      end else begin
        case (phase_r)
          PH_LOAD: begin
            if (g_done) begin
              gather_nxt = '0;
              bpos_nxt   = '0;
              if ({1'b0, count_r} < DEPTH17) begin
                pal_wr.we   = 1'b1;
                pal_wr.addr = count_r[7:0];
                pal_wr.data = unpack_color(cfg.map_entry_format, gv);
              end
              count_nxt = count_r + 16'd1;
              if (count_nxt >= cfg.map_entries) begin
                phase_nxt = PH_PIX;
              end
            end else begin
              gather_nxt = gv[23:0];
              bpos_nxt   = bpos_r + 2'd1;
            end
          end
          PH_PIX: begin
            if (rep_left_r != 7'd0) begin
              err = 1'b1;
            end else if (cfg.rle_enabled && pkt_left_r == 8'd0) begin
              pkt_rep_nxt  = in_ch.data_byte[7];
              pkt_left_nxt = {1'b0, in_ch.data_byte[6:0]} + 8'd1;
            end else if (g_done) begin
              gather_nxt = '0;
              bpos_nxt   = '0;
              emit       = 1'b1;
              if (cfg.rle_enabled) begin
                if (pkt_rep_r) begin
                  rep_raw_nxt  = gv;
                  rep_src_nxt  = px_src;
                  rep_fmt_nxt  = cfg.pixel_format;
                  rep_left_nxt = 7'(pkt_left_r - 8'd1);
                  pkt_left_nxt = '0;
                end else begin
                  pkt_left_nxt = pkt_left_r - 8'd1;
                end
              end
            end else begin
              gather_nxt = gv[23:0];
              bpos_nxt   = bpos_r + 2'd1;
            end
          end
          default: begin
            err = 1'b1;
          end
        endcase
      end
    end

    if (emit) begin
      push      = 1'b1;
      job.src   = e_src;
      job.fmt   = e_fmt;
      job.raw   = e_raw;
      job.pos_x = cfg.origin_flags[0] ? (w16 - 16'd1 - col_r) : col_r;
      job.pos_y = cfg.origin_flags[1] ? row_r : (h16 - 16'd1 - row_r);
      if (col_last) begin
        col_nxt = '0;
        if (row_last) begin
          job.image_done = 1'b1;
          phase_nxt      = PH_DONE;
          rep_left_nxt   = '0;
          pkt_left_nxt   = '0;
        end else begin
          row_nxt = row_r + 16'd1;
        end
      end else begin
        col_nxt = col_r + 16'd1;
      end
      job.run_pending = rep_left_nxt != 7'd0;
    end else if (err) begin
      push            = 1'b1;
      job.src         = SRC_ERROR;
      job.run_pending = rep_left_r != 7'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      phase_r    <= start_load ? PH_LOAD : PH_PIX;
      count_r    <= '0;
      gather_r   <= '0;
      bpos_r     <= '0;
      pkt_left_r <= '0;
      pkt_rep_r  <= 1'b0;
      rep_raw_r  <= '0;
      rep_src_r  <= SRC_DIRECT;
      rep_fmt_r  <= FMT_GREY8;
      rep_left_r <= '0;
      col_r      <= '0;
      row_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      count_r    <= count_nxt;
      gather_r   <= gather_nxt;
      bpos_r     <= bpos_nxt;
      pkt_left_r <= pkt_left_nxt;
      pkt_rep_r  <= pkt_rep_nxt;
      rep_raw_r  <= rep_raw_nxt;
      rep_src_r  <= rep_src_nxt;
      rep_fmt_r  <= rep_fmt_nxt;
      rep_left_r <= rep_left_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/tga_psd_back.sv =====
// ----------------------------------------------------------------------------
// TGA decoder back end
// Result queue, palette store, colour resolution and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_psd_back
  import tga_psd_pkg::*;
#(
  parameter int MAP_DEPTH = MapDepthDflt
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire job_t    job,
  input  wire pal_wr_t pal_wr,
  output      logic    q_full,
  tga_psd_out_if.source out_ch
);

  localparam int AW = $clog2(MAP_DEPTH);

  job_t            q_mem [QueueDepth];
  logic [QueueAw-1:0] wr_ptr_r, rd_ptr_r;
  logic [QueueAw:0]   cnt_r, cnt_nxt;
  logic            q_nempty, pop;

  logic [31:0]     pal_mem [MAP_DEPTH];
  logic [31:0]     pal_rd_r;

  logic            s1_v_r;
  job_t            s1_job_r;
  logic            en1, adv2;

  logic            out_v_r;
  job_t            out_job_r;
  logic [31:0]     out_col_r, col_nxt;

  assign q_full   = cnt_r == (QueueAw + 1)'(QueueDepth);
  assign q_nempty = cnt_r != '0;
  assign adv2     = !out_v_r || out_ch.ready;
  assign en1      = !s1_v_r || adv2;
  assign pop      = q_nempty && en1;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (en1) begin
        s1_v_r <= q_nempty;
      end
      if (adv2) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= job;
    end
    if (pop) begin
      s1_job_r <= q_mem[rd_ptr_r];
    end
  end

  // Palette: written during map loading, read as an indexed entry leaves the queue.
  always_ff @(posedge clk) begin
    if (pal_wr.we) begin
      pal_mem[pal_wr.addr[AW-1:0]] <= pal_wr.data;
    end
    if (pop && q_mem[rd_ptr_r].src == SRC_INDEX) begin
      pal_rd_r <= pal_mem[q_mem[rd_ptr_r].raw[AW-1:0]];
    end
  end

  always_comb begin
    case (s1_job_r.src)
      SRC_DIRECT:  col_nxt = unpack_color(s1_job_r.fmt, s1_job_r.raw);
      SRC_INDEX:   col_nxt = pal_rd_r;
      SRC_MAGENTA: col_nxt = MAGENTA;
      default:     col_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_v_r) begin
      out_job_r <= s1_job_r;
      out_col_r <= col_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.pos_x       = out_job_r.pos_x;
  assign out_ch.pos_y       = out_job_r.pos_y;
  assign out_ch.red         = out_col_r[31:24];
  assign out_ch.green       = out_col_r[23:16];
  assign out_ch.blue        = out_col_r[15:8];
  assign out_ch.alpha       = out_col_r[7:0];
  assign out_ch.run_pending = out_job_r.run_pending;
  assign out_ch.image_done  = out_job_r.image_done;
  assign out_ch.error       = out_job_r.src == SRC_ERROR;

endmodule

`default_nettype wire

// ===== src/tga_psd_checker.sv =====
// ----------------------------------------------------------------------------
// TGA decoder port checker
// Watches the result channel of the decoder core over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tga_pixel_stream_decoder_core_assert.svh"

module tga_psd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_pos_x,
  input wire logic [15:0] out_pos_y,
  input wire logic [7:0]  out_red,
  input wire logic [7:0]  out_green,
  input wire logic [7:0]  out_blue,
  input wire logic [7:0]  out_alpha,
  input wire logic        out_image_done,
  input wire logic        out_error
);

  `TPSD_ASSERT_HOLD(a_out_hold, clk, rst_n, out_valid, out_ready)

  `TPSD_ASSERT(a_err_zero, clk, rst_n, (out_valid && out_error) |-> (out_pos_x == 16'd0 && out_pos_y == 16'd0 && out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0 && out_alpha == 8'd0 && !out_image_done))

  `TPSD_ASSERT(a_done_not_err, clk, rst_n, out_valid |-> !(out_error && out_image_done))

  `TPSD_ASSERT(a_idle_after_rst, clk, rst_n, $rose(rst_n) |-> !out_valid)

endmodule

bind tga_pixel_stream_decoder_core tga_psd_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_pos_x      (out_ch.pos_x),
  .out_pos_y      (out_ch.pos_y),
  .out_red        (out_ch.red),
  .out_green      (out_ch.green),
  .out_blue       (out_ch.blue),
  .out_alpha      (out_ch.alpha),
  .out_image_done (out_ch.image_done),
  .out_error      (out_ch.error)
);

`default_nettype wire
